/* hw/rtl/twps_pkg.sv */
// Shared types for the trapped-water block: request/response beats and the
// accumulator control group. No dependencies.
`default_nettype none

package twps_pkg;

   localparam int unsigned HEIGHT_W = 16;
   localparam int unsigned WATER_W  = 26;

   typedef struct packed {
      logic [HEIGHT_W-1:0] height;
      logic                last;
   } req_type;

   typedef struct packed {
      logic [WATER_W-1:0] water_total;
      logic               overflow;
   } rsp_type;

   typedef struct packed {
      logic clear;   // start of a new backward pass
      logic vld;     // read data from the store is valid this cycle
   } acc_ctl_type;

endpackage

`default_nettype wire

/* hw/rtl/twps_mem.sv */
// Height / prefix-max store: one write port, one read port, registered read.
// Depends on nothing.
`default_nettype none

module twps_mem #(
   parameter int unsigned DEPTH = 1024,
   parameter int unsigned AW    = 10,
   parameter int unsigned DW    = 32
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [DW-1:0] wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hw/rtl/twps_acc.sv */
// Backward-pass datapath: running suffix max, water level, saturating sum.
// Two stages. Depends on twps_pkg.
`default_nettype none

module twps_acc
   import twps_pkg::*;
#(
   parameter int unsigned HW = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire acc_ctl_type         ctl,
   input  wire logic [HW-1:0]       hgt,
   input  wire logic [HW-1:0]       pre,
   output logic      [WATER_W-1:0]  sum,
   output logic                     idle
);

   logic [HW-1:0]      suffix_ff, suffix_in;
   logic [HW-1:0]      diff_ff, diff_in;
   logic               dvld_ff, dvld_in;
   logic [WATER_W-1:0] sum_ff, sum_in;
   logic [HW-1:0]      level;
   logic [WATER_W:0]   tot;

   always_comb begin
      suffix_in = (hgt > suffix_ff) ? hgt : suffix_ff;
      level     = (pre < suffix_in) ? pre : suffix_in;
      diff_in   = level - hgt;
      dvld_in   = ctl.vld;
      tot       = {1'b0, sum_ff} + (WATER_W+1)'(diff_ff);
      // saturate at all ones
      sum_in    = tot[WATER_W] ? {WATER_W{1'b1}} : tot[WATER_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         suffix_ff <= '0;
         dvld_ff   <= 1'b0;
         sum_ff    <= '0;
      end else begin
         if (ctl.vld) begin
            suffix_ff <= suffix_in;
         end
         dvld_ff <= dvld_in;
         if (dvld_ff) begin
            sum_ff <= sum_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      diff_ff <= diff_in;
   end

   assign sum  = sum_ff;
   assign idle = !dvld_ff;

endmodule

`default_nettype wire

/* hw/rtl/trapped_water_prefix_suffix_max.sv */
// Trapped rain water, prefix/suffix maximum method.
//
// req channel: one bar height per beat, last marks the final height.
// rsp channel: one beat per array, the trapped water total and an overflow bit.
// While loading, each height is written to the store as it is accepted,
// together with the running prefix max. Heights beyond MAX_LEN are dropped
// and flag overflow; a dropped beat with last still closes the array.
// After last, req_ready drops and the store is walked backward from the final
// entry to entry 0, one read per cycle. The walk is followed by a drain and a
// finish state; req_ready returns when the result enters the rsp register.
// A new array is not taken while the walk uses the single store read port.
// The rsp register holds the result while the receiver stalls; a new array
// loads meanwhile, and its result waits until the old one is taken.
// Reset (synchronous) empties the array state and clears rsp_valid; store
// contents are not cleared and need no clearing pass.
// Depends on twps_pkg, twps_mem, twps_acc.
`default_nettype none

module trapped_water_prefix_suffix_max
   import twps_pkg::*;
#(
   parameter int unsigned MAX_LEN     = 1024,
   parameter int unsigned HEIGHT_BITS = 16
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   localparam int unsigned HW = (HEIGHT_BITS < HEIGHT_W) ? HEIGHT_BITS : HEIGHT_W;
   localparam int unsigned AW = $clog2(MAX_LEN);
   localparam int unsigned CW = $clog2(MAX_LEN + 1);

   typedef enum logic [3:0] {
      ST_LOAD   = 4'b0001,
      ST_WALK   = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type     state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [HW-1:0] rmax_ff, rmax_in;
   logic          ovf_ff, ovf_in;
   logic [AW-1:0] raddr_ff, raddr_in;
   logic          rvld_ff, rvld_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;

   logic          req_fire, has_room, rd_en, acc_idle;
   logic [HW-1:0] hgt;
   logic [2*HW-1:0] rd_word;
   logic [WATER_W-1:0] acc_sum;
   acc_ctl_type   acc_ctl;

   assign hgt      = req_data.height[HW-1:0];
   assign req_ready = (state_ff == ST_LOAD);
   assign req_fire = req_valid && req_ready;
   assign has_room = (cnt_ff < CW'(MAX_LEN));
   assign rd_en    = (state_ff == ST_WALK);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rmax_in      = rmax_ff;
      ovf_in       = ovf_ff;
      raddr_in     = raddr_ff;
      rvld_in      = rd_en;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      acc_ctl      = '{clear: 1'b0, vld: rvld_ff};

      case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               if (has_room) begin
                  rmax_in = (hgt > rmax_ff) ? hgt : rmax_ff;
                  cnt_in  = cnt_ff + CW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_data.last) begin
                  // cnt_in >= 1 here, so the walk starts at the final entry
                  raddr_in      = AW'(cnt_in - CW'(1));
                  acc_ctl.clear = 1'b1;
                  state_in      = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            raddr_in = raddr_ff - AW'(1);
            if (raddr_ff == '0) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rvld_ff && acc_idle) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.water_total = acc_sum;
               rsp_data_in.overflow    = ovf_ff;
               cnt_in                  = '0;
               rmax_in                 = '0;
               ovf_in                  = 1'b0;
               state_in                = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         cnt_ff       <= '0;
         rmax_ff      <= '0;
         ovf_ff       <= 1'b0;
         rvld_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rmax_ff      <= rmax_in;
         ovf_ff       <= ovf_in;
         rvld_ff      <= rvld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      raddr_ff    <= raddr_in;
      rsp_data_ff <= rsp_data_in;
   end

   twps_mem #(
      .DEPTH (MAX_LEN),
      .AW    (AW),
      .DW    (2 * HW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (req_fire && has_room),
      .wr_addr (cnt_ff[AW-1:0]),
      .wr_data ({hgt, rmax_in}),
      .rd_en   (rd_en),
      .rd_addr (raddr_ff),
      .rd_data (rd_word)
   );

   twps_acc #(
      .HW (HW)
   ) u_acc (
      .clock (clock),
      .reset (reset),
      .ctl   (acc_ctl),
      .hgt   (rd_word[2*HW-1:HW]),
      .pre   (rd_word[HW-1:0]),
      .sum   (acc_sum),
      .idle  (acc_idle)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

/* hw/rtl/twps_chk.sv */
// Port-level checks for the trapped-water block, bound to the top level.
// Depends on twps_pkg.
`default_nettype none

module twps_chk
   import twps_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   // closing beat starts the backward pass: input stalls
   a_last_stalls: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.last |=> !req_ready)
      else $error("req_ready high right after last beat");

   // a result appears only out of the pass, never during loading
   a_rsp_after_pass: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared while loading");

endmodule

bind trapped_water_prefix_suffix_max twps_chk u_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

/* sim/tb.sv */
// Self-checking testbench for trapped_water_prefix_suffix_max: random and directed height
// arrays, with a built-in prefix/suffix-max predictor checking every response beat.
// Depends on twps_pkg and the trapped_water_prefix_suffix_max RTL.
`default_nettype none

module tb;
   import twps_pkg::*;

   localparam int unsigned MAX_BARS     = 1024;
   localparam int unsigned BAR_AW       = $clog2(MAX_BARS);
   localparam int unsigned TARGET_BEATS = 1850;
   localparam int unsigned TAIL_BEATS   = 150;   // no idling once this few remain
   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int unsigned STALL_LIMIT  = 5000;
   localparam longint unsigned SUM_CAP  = (64'd1 << WATER_W) - 1;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   trapped_water_prefix_suffix_max dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // stimulus and scoreboard
   req_type     height_queue[$];
   rsp_type     water_expect[$];
   int unsigned beats_total   = 0;
   int unsigned beats_taken   = 0;
   int unsigned arrays_sent   = 0;
   int unsigned longest_array = 0;
   int unsigned totals_seen   = 0;
   int unsigned spills_seen   = 0;
   int unsigned fail_count    = 0;

   // predictor state
   logic [HEIGHT_W-1:0] bar_mem  [0:MAX_BARS-1];
   logic [HEIGHT_W-1:0] peak_mem [0:MAX_BARS-1];
   int unsigned         bar_count   = 0;
   logic [HEIGHT_W-1:0] peak_so_far = '0;
   bit                  dropped     = 1'b0;

   // Takes one height beat; returns 1 with the water total when the beat closes an array.
   function automatic bit fold_height(input req_type beat, output rsp_type total);
      logic [HEIGHT_W-1:0] h;
      logic [HEIGHT_W-1:0] suffix;
      logic [HEIGHT_W-1:0] level;
      logic [BAR_AW-1:0]   slot;
      longint unsigned     sum;
      int                  i;
      h     = beat.height;
      total = '0;
      if (bar_count < MAX_BARS) begin
         slot = bar_count[BAR_AW-1:0];
         if (h > peak_so_far) peak_so_far = h;
         bar_mem[slot]  = h;
         peak_mem[slot] = peak_so_far;
         bar_count++;
      end else begin
         dropped = 1'b1;
      end
      if (!beat.last) return 1'b0;
      sum = 0;
      if (bar_count >= 3) begin
         slot   = BAR_AW'(bar_count - 1);
         suffix = bar_mem[slot];
         for (i = int'(bar_count) - 2; i >= 1; i--) begin
            slot = i[BAR_AW-1:0];
            if (bar_mem[slot] > suffix) suffix = bar_mem[slot];
            level = (peak_mem[slot] < suffix) ? peak_mem[slot] : suffix;
            sum += 64'(level - bar_mem[slot]);
            if (sum > SUM_CAP) sum = SUM_CAP;
         end
      end
      total.water_total = sum[WATER_W-1:0];
      total.overflow    = dropped;
      bar_count   = 0;
      peak_so_far = '0;
      dropped     = 1'b0;
      return 1'b1;
   endfunction

   task automatic push_height(input logic [HEIGHT_W-1:0] h, input bit is_last,
                              input int unsigned len);
      req_type beat;
      beat.height = h;
      beat.last   = is_last;
      height_queue.push_back(beat);
      beats_total++;
      if (is_last) begin
         arrays_sent++;
         if (len > longest_array) longest_array = len;
      end
   endtask

   // driver: beats from height_queue, prediction on each accepted beat
   int unsigned src_gap = 0;

   always @(posedge clock) begin : drive_heights
      rsp_type total;
      bit      idle_ok;
      if (reset) begin
         req_valid <= 1'b0;
         src_gap   <= 0;
      end else begin
         if (req_valid && req_ready) begin
            beats_taken <= beats_taken + 1;
            if (fold_height(req_data, total)) water_expect.push_back(total);
         end
         idle_ok = height_queue.size() > TAIL_BEATS && ((beats_taken / 100) % 4) != 3;
         if (!req_valid || req_ready) begin
            if (src_gap != 0) begin
               src_gap   <= src_gap - 1;
               req_valid <= 1'b0;
            end else if (idle_ok && $urandom_range(0, 4) == 0) begin
               src_gap   <= $urandom_range(0, 5);
               req_valid <= 1'b0;
            end else if (height_queue.size() != 0) begin
               req_data  <= height_queue.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: response checks and rsp_ready pattern, including one long hold-off
   int unsigned sink_gap  = 0;
   int unsigned hold_left = 0;
   bit          hold_done = 1'b0;

   always @(posedge clock) begin : check_totals
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            totals_seen++;
            if (rsp_data.overflow) spills_seen++;
            if (water_expect.size() == 0) begin
               $error("unexpected response beat: water_total %0d overflow %0d",
                      rsp_data.water_total, rsp_data.overflow);
               fail_count++;
            end else begin
               want = water_expect.pop_front();
               if (rsp_data.water_total !== want.water_total) begin
                  $error("water_total mismatch: expected %0d, got %0d",
                         want.water_total, rsp_data.water_total);
                  fail_count++;
               end
               if (rsp_data.overflow !== want.overflow) begin
                  $error("overflow mismatch: expected %0d, got %0d",
                         want.overflow, rsp_data.overflow);
                  fail_count++;
               end
            end
         end
         if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else if (!hold_done && totals_seen == 30) begin
            // long stall so the block fills up and backpressures req
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES - 1;
            rsp_ready <= 1'b0;
         end else if (sink_gap != 0) begin
            sink_gap  <= sink_gap - 1;
            rsp_ready <= 1'b0;
         end else if (height_queue.size() > TAIL_BEATS && ((totals_seen / 16) % 3) != 2
                      && $urandom_range(0, 3) == 0) begin
            sink_gap  <= $urandom_range(0, 5);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog: cycles with no beat on either channel
   int unsigned stall_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("trapped_water_prefix_suffix_max verification failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin : run_arrays
      int unsigned len;
      int unsigned mode;
      int unsigned k;
      logic [HEIGHT_W-1:0] h;

      // short arrays, flat, monotone and extreme shapes
      push_height(16'd7, 1'b1, 1);
      push_height(16'd0, 1'b0, 2);
      push_height(16'hFFFF, 1'b1, 2);
      push_height(16'hFFFF, 1'b0, 3);
      push_height(16'd0, 1'b0, 3);
      push_height(16'hFFFF, 1'b1, 3);
      push_height(16'd0, 1'b0, 3);
      push_height(16'd0, 1'b0, 3);
      push_height(16'd0, 1'b1, 3);
      push_height(16'd3, 1'b0, 5);
      push_height(16'd0, 1'b0, 5);
      push_height(16'd2, 1'b0, 5);
      push_height(16'd0, 1'b0, 5);
      push_height(16'd4, 1'b1, 5);
      push_height(16'd1, 1'b0, 4);
      push_height(16'd2, 1'b0, 4);
      push_height(16'd3, 1'b0, 4);
      push_height(16'd4, 1'b1, 4);
      push_height(16'hFFFF, 1'b0, 4);
      push_height(16'h8000, 1'b0, 4);
      push_height(16'h7FFF, 1'b0, 4);
      push_height(16'd1, 1'b1, 4);
      push_height(16'h00FF, 1'b0, 3);
      push_height(16'hFF00, 1'b0, 3);
      push_height(16'h5555, 1'b1, 3);

      // full store: deepest possible well, then two dropped beats, last on a dropped one
      for (k = 0; k < MAX_BARS + 2; k++) begin
         h = (k == 0 || k >= MAX_BARS - 1) ? 16'hFFFF : 16'd0;
         push_height(h, k == MAX_BARS + 1, MAX_BARS + 2);
      end
      // overflow must not stick to the next array
      push_height(16'd9, 1'b0, 3);
      push_height(16'd1, 1'b0, 3);
      push_height(16'd9, 1'b1, 3);

      while (beats_total < TARGET_BEATS) begin
         len  = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 60) : $urandom_range(1, 16);
         mode = $urandom_range(0, 3);
         for (k = 0; k < len; k++) begin
            case (mode)
               0: h = 16'($urandom_range(0, 65535));
               1: h = 16'($urandom_range(0, 15));
               2: h = $urandom_range(0, 1) ? 16'hFFFF - 16'($urandom_range(0, 3))
                                           : 16'($urandom_range(0, 3));
               default: h = (k < len / 2) ? 16'hFFFF - 16'(k * 997) : 16'(k * 1231);
            endcase
            push_height(h, k == len - 1, len);
         end
      end

      wait (beats_taken == beats_total && water_expect.size() == 0);
      repeat (20) @(posedge clock);
      $display("covered %0d arrays in %0d height beats, longest array %0d beats",
               arrays_sent, beats_total, longest_array);
      $display("checked %0d totals, %0d with overflow, one %0d-cycle rsp hold-off",
               totals_seen, spills_seen, HOLD_CYCLES);
      if (fail_count == 0 && totals_seen == arrays_sent) begin
         $display("trapped_water_prefix_suffix_max verification clean");
      end else begin
         $display("trapped_water_prefix_suffix_max verification failed");
      end
      $finish;
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

endmodule

`default_nettype wire

/* sim.f */
hw/rtl/twps_pkg.sv
hw/rtl/twps_mem.sv
hw/rtl/twps_acc.sv
hw/rtl/trapped_water_prefix_suffix_max.sv
hw/rtl/twps_chk.sv
sim/tb.sv
